FILE: src/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, codes and the per-command line step table of the I2C master
// bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_ACK   = 3'd2;
    localparam logic [2:0] OP_NACK  = 3'd3;
    localparam logic [2:0] OP_CHECK = 3'd4;
    localparam logic [2:0] OP_WRITE = 3'd5;
    localparam logic [2:0] OP_READ  = 3'd6;
    localparam logic [2:0] OP_NONE  = 3'd7;

    localparam logic       CFG_STEP_DELAY = 1'b0;
    localparam logic       CFG_POLL_LIMIT = 1'b1;

    localparam logic [7:0]  STEP_DELAY_RESET = 8'd5;
    localparam logic [15:0] POLL_LIMIT_RESET = 16'd5000;

    localparam logic [1:0] VAL_ZERO = 2'd0;
    localparam logic [1:0] VAL_ONE  = 2'd1;
    localparam logic [1:0] VAL_BIT  = 2'd2;

    localparam int STEP_W = 5;

    typedef struct packed {
        logic       to_sda;
        logic [1:0] val;
        logic       last;
        logic       rd_end;
        logic       ck_end;
    } t_action;

    typedef struct packed {
        logic              load;
        logic              apply;
        logic [STEP_W-1:0] step;
        t_action           act;
    } t_cmd;

    function automatic t_action mk(input logic to_sda, input logic [1:0] val,
                                   input logic last);
        t_action a;
        a.to_sda = to_sda;
        a.val    = val;
        a.last   = last;
        a.rd_end = 1'b0;
        a.ck_end = 1'b0;
        return a;
    endfunction

    function automatic t_action step_action(input logic [2:0] op,
                                            input logic [STEP_W-1:0] idx);
        t_action a;
        a = mk(1'b0, VAL_ZERO, 1'b1);
        case (op)
            OP_START, OP_STOP: begin
                case (idx[2:0])
                    3'd0:    a = mk(1'b0, VAL_ZERO, 1'b0);
                    3'd1:    a = mk(1'b1, (op == OP_START) ? VAL_ONE : VAL_ZERO, 1'b0);
                    3'd2:    a = mk(1'b0, VAL_ONE, 1'b0);
                    3'd3:    a = mk(1'b1, (op == OP_START) ? VAL_ZERO : VAL_ONE, 1'b0);
                    default: a = mk(1'b0, VAL_ZERO, 1'b1);
                endcase
            end
            OP_ACK, OP_NACK: begin
                case (idx[2:0])
                    3'd0:    a = mk(1'b0, VAL_ZERO, 1'b0);
                    3'd1:    a = mk(1'b1, (op == OP_NACK) ? VAL_ONE : VAL_ZERO, 1'b0);
                    3'd2:    a = mk(1'b0, VAL_ONE, 1'b0);
                    3'd3:    a = mk(1'b0, VAL_ZERO, 1'b0);
                    default: a = mk(1'b1, VAL_ZERO, 1'b1);
                endcase
            end
            OP_CHECK: begin
                if (idx[0] == 1'b0) begin
                    a = mk(1'b0, VAL_ONE, 1'b0);
                end else begin
                    a = mk(1'b0, VAL_ZERO, 1'b1);
                    a.ck_end = 1'b1;
                end
            end
            OP_WRITE: begin
                case (idx[1:0])
                    2'd0:    a = mk(1'b1, VAL_BIT, 1'b0);
                    2'd1:    a = mk(1'b0, VAL_ONE, 1'b0);
                    2'd2:    a = mk(1'b0, VAL_ZERO, 1'b0);
                    default: a = mk(1'b1, VAL_ZERO, idx[4:2] == 3'd7);
                endcase
            end
            OP_READ: begin
                if (idx[0] == 1'b0) begin
                    a = mk(1'b0, VAL_ONE, 1'b0);
                end else begin
                    a = mk(1'b0, VAL_ZERO, idx[3:1] == 3'd7);
                    a.rd_end = (idx[3:1] == 3'd7);
                end
            end
            default: a = mk(1'b0, VAL_ZERO, 1'b1);
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: src/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Sequencer state machine: accepts commands, walks the step table, hands
// each line change to the output and waits the programmed delay.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [2:0]   i_opcode,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [15:0]  i_cfg_data,
    output i2cms_pkg::t_cmd   o_cmd
);
    import i2cms_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [2:0]        r_op;
    logic [STEP_W-1:0] r_step, n_step;
    logic [7:0]        r_cnt, n_cnt;
    logic [7:0]        r_delay;
    logic              r_last, n_last;
    logic              in_acc, out_acc;
    t_action           act;

    assign in_acc  = i_in_valid && (r_state == S_IDLE);
    assign out_acc = (r_state == S_OUT) && !i_out_stall;
    assign act     = step_action(r_op, r_step);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_last  = r_last;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_opcode != OP_NONE)) begin
                    n_state = S_STEP;
                    n_step  = '0;
                end
            end
            S_STEP: begin
                n_state = S_OUT;
                n_last  = act.last;
            end
            S_OUT: begin
                if (out_acc) begin
                    n_state = S_WAIT;
                    n_cnt   = r_delay;
                end
            end
            S_WAIT: begin
                if (r_cnt == 8'd0) begin
                    n_state = r_last ? S_IDLE : S_STEP;
                    n_step  = r_step + STEP_W'(1);
                end else begin
                    n_cnt = r_cnt - 8'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_cnt   <= '0;
            r_last  <= 1'b0;
            r_op    <= OP_NONE;
            r_delay <= STEP_DELAY_RESET;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            if (in_acc) begin
                r_op <= i_opcode;
            end
            if (i_cfg_we && (i_cfg_index == CFG_STEP_DELAY)) begin
                r_delay <= i_cfg_data[7:0];
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = in_acc;
    assign o_cmd.apply = (r_state == S_STEP);
    assign o_cmd.step  = r_step;
    assign o_cmd.act   = act;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result pending while input is open");

    a_beat_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> (r_state == S_WAIT))
        else $error("output beat not followed by the delay");

    a_apply_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> o_out_valid)
        else $error("line change not presented");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_op != OP_WRITE) |-> (r_step[4] == 1'b0))
        else $error("step index past command length");

endmodule

`default_nettype wire

FILE: src/i2cms_dp.sv
// ----------------------------------------------------------------------------
// i2cms_dp
// Datapath: command operands, SCL and SDA line registers, read shift
// register, ack check and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_dp (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire i2cms_pkg::t_cmd i_cmd,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic [7:0]   i_sampled_bits,
    input  wire logic [15:0]  i_ack_high_polls,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [15:0]  i_cfg_data,
    output logic              o_scl_level,
    output logic              o_sda_level,
    output logic              o_last_step,
    output logic [7:0]        o_read_byte,
    output logic              o_ack_missing
);
    import i2cms_pkg::*;

    logic        r_scl, r_sda;
    logic [7:0]  r_shift, r_data, r_rbyte;
    logic [15:0] r_limit;
    logic        r_miss_pend, r_miss, r_last;
    logic [15:0] lim;
    logic        lvl;

    assign lim = (r_limit == 16'd0) ? 16'd1 : r_limit;

    always_comb begin
        case (i_cmd.act.val)
            VAL_ONE: lvl = 1'b1;
            VAL_BIT: lvl = r_data[~i_cmd.step[4:2]];
            default: lvl = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl   <= 1'b0;
            r_sda   <= 1'b0;
            r_shift <= 8'd0;
            r_limit <= POLL_LIMIT_RESET;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_POLL_LIMIT)) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.apply) begin
                if (i_cmd.act.to_sda) begin
                    r_sda <= lvl;
                end else begin
                    r_scl <= lvl;
                end
            end
            if (i_cmd.load) begin
                r_data      <= i_data_byte;
                r_miss_pend <= (i_ack_high_polls >= lim);
            end
            if (i_cmd.load) begin
                r_shift <= i_sampled_bits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_last  <= i_cmd.act.last;
            r_rbyte <= i_cmd.act.rd_end ? r_shift : 8'd0;
            r_miss  <= i_cmd.act.ck_end & r_miss_pend;
        end
    end

    assign o_scl_level   = r_scl;
    assign o_sda_level   = r_sda;
    assign o_last_step   = r_last;
    assign o_read_byte   = r_rbyte;
    assign o_ack_missing = r_miss;

endmodule

`default_nettype wire

FILE: src/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master line sequencer: one command per input beat, one output beat per
// SCL or SDA line change, last beat of each command marked.
// ----------------------------------------------------------------------------
// Each line change is applied in the step state, then presented as one output
// beat (held while the output stalls), then followed by the step delay wait.
// A command of N changes (2 to 32) is paced by the step delay counter, and
// only one command is taken at a time.
// Synchronous active-low reset clears the lines and the shift register and
// loads step_delay 5 and ack_poll_limit 5000.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [2:0]   i_opcode,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic [7:0]   i_sampled_bits,
    input  wire logic [15:0]  i_ack_high_polls,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic              o_scl_level,
    output logic              o_sda_level,
    output logic              o_last_step,
    output logic [7:0]        o_read_byte,
    output logic              o_ack_missing,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [15:0]  i_cfg_data
);
    import i2cms_pkg::*;

    t_cmd cmd;

    i2cms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd)
    );

    i2cms_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_data_byte      (i_data_byte),
        .i_sampled_bits   (i_sampled_bits),
        .i_ack_high_polls (i_ack_high_polls),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_scl_level      (o_scl_level),
        .o_sda_level      (o_sda_level),
        .o_last_step      (o_last_step),
        .o_read_byte      (o_read_byte),
        .o_ack_missing    (o_ack_missing)
    );

endmodule

`default_nettype wire
